### hdl/assert_macros.svh
// Assertion helpers for the RTL, used by msta_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define MSTA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define MSTA_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hdl/msta_pkg.sv
`timescale 1ns / 1ps

package msta_pkg;

   localparam int TS_W            = 32;
   localparam int IDX_W           = 24;
   localparam int SID_W           = 2;
   localparam int FIFO_SLOTS      = 2;
   localparam int MAX_RESULTS     = 4;
   localparam int NUM_STREAMS_DEF = 4;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic [TS_W-1:0] TOL_RESET = 32'd33333;

   typedef struct packed {
      logic [SID_W-1:0] stream_id;
      logic [TS_W-1:0]  timestamp;
   } req_word_type;

   typedef struct packed {
      logic [SID_W-1:0] out_stream;
      logic [IDX_W-1:0] frame_index;
      logic             last;
      logic             overflow;
   } rsp_word_type;

   // front -> back: head of the hand-off queue
   typedef struct packed {
      logic         valid;
      req_word_type word;
   } fwd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_SETTLE,
      ST_JUDGE,
      ST_DROP,
      ST_EMIT
   } back_state_type;

endpackage

### hdl/msta_front.sv
`timescale 1ns / 1ps

// Takes request words, drops stream ids out of range, queues the rest.
module msta_front #(
   parameter int NUM_STREAMS = msta_pkg::NUM_STREAMS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  msta_pkg::req_word_type req_word,
   output msta_pkg::fwd_type     fwd,
   input  logic                  pop
);

   localparam int PTR_W = (msta_pkg::FIFO_SLOTS > 1) ? $clog2(msta_pkg::FIFO_SLOTS) : 1;
   localparam int CNT_W = $clog2(msta_pkg::FIFO_SLOTS + 1);

   msta_pkg::req_word_type slot_ff [msta_pkg::FIFO_SLOTS];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             in_range;
   logic             push;
   logic             do_pop;

   // not ready while in reset, so no word is taken and lost
   assign req_ready = ~reset & (count_ff != CNT_W'(msta_pkg::FIFO_SLOTS));
   assign in_range  = (32'(req_word.stream_id) < 32'(NUM_STREAMS));
   assign push      = req_valid & req_ready & in_range;
   assign do_pop    = pop & (count_ff != '0);

   assign fwd.valid = (count_ff != '0);
   assign fwd.word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(msta_pkg::FIFO_SLOTS - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(msta_pkg::FIFO_SLOTS - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_word;
      end
   end

endmodule

### hdl/msta_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Per-stream timestamp queues, head compare and matched-set output.
module msta_back #(
   parameter int NUM_STREAMS = msta_pkg::NUM_STREAMS_DEF,
   parameter int QUEUE_DEPTH = msta_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  msta_pkg::fwd_type            fwd,
   output logic                         pop,
   input  logic                         csr_wr_en,
   input  logic [msta_pkg::TS_W-1:0]    csr_wr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output msta_pkg::rsp_word_type       rsp_word
);

   localparam int SW = $clog2(NUM_STREAMS);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(NUM_STREAMS * QUEUE_DEPTH);
   localparam int TW = msta_pkg::TS_W;
   localparam int IW = msta_pkg::IDX_W;

   msta_pkg::back_state_type state_ff, state_in;

   logic [TW-1:0] head_mem_ff [NUM_STREAMS * QUEUE_DEPTH];
   logic [TW-1:0] rd_data_ff;

   logic [CW-1:0] cnt_ff   [NUM_STREAMS];
   logic [CW-1:0] cnt_in   [NUM_STREAMS];
   logic [PW-1:0] rdptr_ff [NUM_STREAMS];
   logic [PW-1:0] rdptr_in [NUM_STREAMS];
   logic [IW-1:0] frame_ff [NUM_STREAMS];
   logic [IW-1:0] frame_in [NUM_STREAMS];

   logic          ovf_ff, ovf_in;
   logic [TW-1:0] tol_ff;
   logic [SW-1:0] scan_ff, scan_in;

   logic          pend_ff;
   logic [SW-1:0] pidx_ff;
   logic [TW-1:0] mn_ff, mn_in;
   logic [TW-1:0] mx_ff, mx_in;
   logic [SW-1:0] mnidx_ff, mnidx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   msta_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [SW-1:0] sel;
   logic [CW-1:0] sel_cnt;
   logic [PW-1:0] sel_rdptr;
   logic [IW-1:0] sel_frame;
   logic          sel_full;
   logic [PW+1:0] wsum;
   logic [PW-1:0] wp;
   logic [PW-1:0] mem_ptr;
   logic [AW-1:0] mem_addr;
   logic          wr_en;
   logic          rd_en;
   logic          all_head;
   logic          slot_free;

   assign sel_cnt   = cnt_ff[sel];
   assign sel_rdptr = rdptr_ff[sel];
   assign sel_frame = frame_ff[sel];
   assign sel_full  = (sel_cnt == CW'(QUEUE_DEPTH));

   // write slot = (head + count) mod depth, sum stays below twice the depth
   assign wsum = (PW+2)'(sel_rdptr) + (PW+2)'(sel_cnt);
   assign wp   = (wsum >= (PW+2)'(QUEUE_DEPTH)) ? PW'(wsum - (PW+2)'(QUEUE_DEPTH))
                                                 : PW'(wsum);
   assign mem_ptr  = wr_en ? wp : sel_rdptr;
   assign mem_addr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(mem_ptr);

   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      all_head = 1'b1;
      for (int i = 0; i < NUM_STREAMS; i++) begin
         if (cnt_ff[i] == '0) begin
            all_head = 1'b0;
         end
      end
   end

   // running min / max over head words as they come out of the memory
   always_comb begin
      mn_in    = mn_ff;
      mx_in    = mx_ff;
      mnidx_in = mnidx_ff;
      if (pend_ff) begin
         if (pidx_ff == '0) begin
            mn_in    = rd_data_ff;
            mx_in    = rd_data_ff;
            mnidx_in = '0;
         end else begin
            if (rd_data_ff < mn_ff) begin
               mn_in    = rd_data_ff;
               mnidx_in = pidx_ff;
            end
            if (rd_data_ff > mx_ff) begin
               mx_in = rd_data_ff;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      ovf_in       = ovf_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      sel          = scan_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_word_in  = rsp_word_ff;
      for (int i = 0; i < NUM_STREAMS; i++) begin
         cnt_in[i]   = cnt_ff[i];
         rdptr_in[i] = rdptr_ff[i];
         frame_in[i] = frame_ff[i];
      end

      case (state_ff)
         msta_pkg::ST_IDLE: begin
            sel = SW'(fwd.word.stream_id);
            if (fwd.valid) begin
               pop = 1'b1;
               if (sel_full) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en       = 1'b1;
                  cnt_in[sel] = sel_cnt + 1'b1;
               end
               state_in = msta_pkg::ST_CHECK;
            end
         end
         msta_pkg::ST_CHECK: begin
            if (all_head) begin
               scan_in  = '0;
               state_in = msta_pkg::ST_SCAN;
            end else begin
               state_in = msta_pkg::ST_IDLE;
            end
         end
         msta_pkg::ST_SCAN: begin
            rd_en = 1'b1;
            if (scan_ff == SW'(NUM_STREAMS - 1)) begin
               state_in = msta_pkg::ST_SETTLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         msta_pkg::ST_SETTLE: begin
            state_in = msta_pkg::ST_JUDGE;
         end
         msta_pkg::ST_JUDGE: begin
            if ((mx_ff - mn_ff) <= tol_ff) begin
               scan_in  = '0;
               state_in = msta_pkg::ST_EMIT;
            end else begin
               state_in = msta_pkg::ST_DROP;
            end
         end
         msta_pkg::ST_DROP: begin
            sel           = mnidx_ff;
            rdptr_in[sel] = (sel_rdptr == PW'(QUEUE_DEPTH - 1)) ? '0 : sel_rdptr + 1'b1;
            cnt_in[sel]   = sel_cnt - 1'b1;
            frame_in[sel] = sel_frame + IW'(1);
            state_in      = msta_pkg::ST_CHECK;
         end
         msta_pkg::ST_EMIT: begin
            if (slot_free) begin
               if (32'(scan_ff) < 32'(msta_pkg::MAX_RESULTS)) begin
                  rsp_valid_in            = 1'b1;
                  rsp_word_in.out_stream  = msta_pkg::SID_W'(scan_ff);
                  rsp_word_in.frame_index = sel_frame;
                  rsp_word_in.last        = (scan_ff == SW'(NUM_STREAMS - 1));
                  rsp_word_in.overflow    = ovf_ff;
               end
               rdptr_in[sel] = (sel_rdptr == PW'(QUEUE_DEPTH - 1)) ? '0 : sel_rdptr + 1'b1;
               cnt_in[sel]   = sel_cnt - 1'b1;
               frame_in[sel] = sel_frame + IW'(1);
               if (scan_ff == SW'(NUM_STREAMS - 1)) begin
                  state_in = msta_pkg::ST_CHECK;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = msta_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msta_pkg::ST_IDLE;
         scan_ff      <= '0;
         ovf_ff       <= 1'b0;
         tol_ff       <= msta_pkg::TOL_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STREAMS; i++) begin
            cnt_ff[i]   <= '0;
            rdptr_ff[i] <= '0;
            frame_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         for (int i = 0; i < NUM_STREAMS; i++) begin
            cnt_ff[i]   <= cnt_in[i];
            rdptr_ff[i] <= rdptr_in[i];
            frame_ff[i] <= frame_in[i];
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      pidx_ff     <= scan_ff;
      mn_ff       <= mn_in;
      mx_ff       <= mx_in;
      mnidx_ff    <= mnidx_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         head_mem_ff[mem_addr] <= fwd.word.timestamp;
      end
      if (rd_en) begin
         rd_data_ff <= head_mem_ff[mem_addr];
      end
   end

   `MSTA_ASSERT(a_full_sets_ovf, clock, reset, (state_ff == msta_pkg::ST_IDLE && fwd.valid && sel_full) |=> ovf_ff, "push to full queue did not flag overflow")
   `MSTA_ASSERT(a_ovf_sticky, clock, reset, ovf_ff |=> ovf_ff, "overflow flag cleared")
   `MSTA_ASSERT(a_scan_has_heads, clock, reset, (state_ff == msta_pkg::ST_SCAN) |-> all_head, "head scan with an empty queue")
   `MSTA_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == msta_pkg::ST_EMIT), "response raised outside emit")

endmodule

### hdl/multi_stream_timestamp_aligner.sv
`timescale 1ns / 1ps

// channel  direction  handshake             payload
// req      in         req_valid/req_ready   req_word  (stream_id, timestamp)
// rsp      out        rsp_valid/rsp_ready   rsp_word  (out_stream, frame_index, last, overflow)
// csr      in         csr_wr_en             csr_wr_data (tolerance, no read-back)
//
// Front takes a word per cycle while its 2-slot queue has room; bad stream ids are dropped there.
// Back: each push is a queue write followed by a head check. Each compare round reads one head per
//   cycle from the timestamp memory; if the spread is within tolerance the set is emitted, else
//   the lowest head is dropped; then heads are checked again. rsp_ready can hold emit.
// Reset is synchronous; counts, pointers and frame counters clear, memory is not cleared.
// Back stalls in emit while the rsp register is full; front stalls only when its queue is full.
module multi_stream_timestamp_aligner #(
   parameter int NUM_STREAMS = msta_pkg::NUM_STREAMS_DEF,
   parameter int QUEUE_DEPTH = msta_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  msta_pkg::req_word_type    req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output msta_pkg::rsp_word_type    rsp_word,
   input  logic                      csr_wr_en,
   input  logic [msta_pkg::TS_W-1:0] csr_wr_data
);

   msta_pkg::fwd_type fwd;
   logic              pop;

   // accept and classify
   msta_front #(
      .NUM_STREAMS(NUM_STREAMS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .fwd      (fwd),
      .pop      (pop)
   );

   // per-stream queues, head compare, matched-set output
   msta_back #(
      .NUM_STREAMS(NUM_STREAMS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fwd        (fwd),
      .pop        (pop),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

### dv/tb_multi_stream_timestamp_aligner.sv
`timescale 1ns / 1ps

module tb_multi_stream_timestamp_aligner;

   localparam int NS           = msta_pkg::NUM_STREAMS_DEF;
   localparam int QD           = msta_pkg::QUEUE_DEPTH_DEF;
   // Worst leftover back-end work once the last set is out: a full sweep of
   // head drops, with margin.
   localparam int DRAIN_CYCLES = 800;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 250000;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_ready;
   msta_pkg::req_word_type         req_word    = '0;
   logic                           rsp_valid;
   logic                           rsp_ready   = 1'b0;
   msta_pkg::rsp_word_type         rsp_word;
   logic                           csr_wr_en   = 1'b0;
   logic [msta_pkg::TS_W-1:0]      csr_wr_data = '0;

   multi_stream_timestamp_aligner u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Alignment predictor: per-stream timestamp rings, frame counters, the
   // sticky overflow bit and its own copy of the tolerance register.
   // ---------------------------------------------------------------------
   bit [msta_pkg::TS_W-1:0]  ts_ring [NS][QD];
   int                       ring_count [NS];
   int                       ring_head [NS];
   bit [msta_pkg::IDX_W-1:0] frame_count [NS];
   bit                       overflow_flag;
   bit [msta_pkg::TS_W-1:0]  tolerance_model = msta_pkg::TOL_RESET;

   msta_pkg::rsp_word_type   match_words_due[$];   // set entries still owed by the DUT
   msta_pkg::req_word_type   req_backlog[$];       // words waiting for the driver

   int  words_queued;
   int  words_accepted;
   int  results_checked;
   int  sets_checked;
   int  fail_count;
   int  cycle_count;
   bit  idle_on = 1'b1;
   int  hold_requests;
   int  holds_served;
   int  req_gap;
   int  rsp_stall;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   function automatic bit all_heads_present();
      for (int s = 0; s < NS; s++)
         if (ring_count[s] == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void retire_head(int s);
      ring_head[s]   = (ring_head[s] + 1) % QD;
      ring_count[s]  = ring_count[s] - 1;
      frame_count[s] = frame_count[s] + 1'b1;
   endfunction

   // One accepted word: queue it (or flag overflow), then keep comparing heads
   // until some stream runs dry. A match emits one entry per stream in order.
   function automatic void align_push(msta_pkg::req_word_type w);
      int                      sid;
      int                      lo_sid;
      bit [msta_pkg::TS_W-1:0] lo;
      bit [msta_pkg::TS_W-1:0] hi;
      bit [msta_pkg::TS_W-1:0] h;
      msta_pkg::rsp_word_type  r;
      sid = int'(w.stream_id);
      if (ring_count[sid] >= QD) begin
         overflow_flag = 1'b1;
      end else begin
         ts_ring[sid][(ring_head[sid] + ring_count[sid]) % QD] = w.timestamp;
         ring_count[sid]++;
      end
      while (all_heads_present()) begin
         lo     = ts_ring[0][ring_head[0]];
         hi     = lo;
         lo_sid = 0;
         for (int s = 1; s < NS; s++) begin
            h = ts_ring[s][ring_head[s]];
            if (h < lo) begin
               lo     = h;
               lo_sid = s;   // strict compare: lowest stream wins a tie
            end
            if (h > hi) hi = h;
         end
         if (hi - lo <= tolerance_model) begin
            for (int s = 0; s < NS; s++) begin
               r.out_stream  = msta_pkg::SID_W'(s);
               r.frame_index = frame_count[s];
               r.last        = (s == NS - 1);
               r.overflow    = overflow_flag;
               match_words_due = {match_words_due, r};
               retire_head(s);
            end
         end else begin
            retire_head(lo_sid);
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_word(int sid, bit [msta_pkg::TS_W-1:0] ts);
      msta_pkg::req_word_type w;
      w.stream_id = msta_pkg::SID_W'(sid);
      w.timestamp = ts;
      req_backlog = {req_backlog, w};
      words_queued++;
   endtask

   // Mostly complete frame sets (one word per stream, shuffled, jittered
   // around a base time that advances), plus sets missing a stream, sets with
   // a doubled frame, and stray words.
   task automatic queue_traffic(int n_words, int unsigned jitter);
      int                      order [NS];
      int                      goal;
      int                      pick;
      int                      j;
      int                      tmp;
      int                      skip;
      int                      extra;
      bit [msta_pkg::TS_W-1:0] base;
      goal = words_queued + n_words;
      base = $urandom;
      while (words_queued < goal) begin
         pick = $urandom_range(0, 9);
         if (pick == 9) begin
            queue_word($urandom_range(0, NS - 1), $urandom);
         end else begin
            for (int i = 0; i < NS; i++) order[i] = i;
            for (int i = NS - 1; i > 0; i--) begin
               j        = $urandom_range(0, i);
               tmp      = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            skip  = (pick == 8) ? $urandom_range(0, NS - 1) : -1;
            extra = (pick == 7) ? $urandom_range(0, NS - 1) : -1;
            for (int i = 0; i < NS; i++) begin
               if (order[i] != skip)
                  queue_word(order[i], base + $urandom_range(0, jitter));
               if (order[i] == extra)
                  queue_word(order[i], base + $urandom_range(0, jitter));
            end
            if ($urandom_range(0, 7) == 0)
               base = $urandom;
            else
               base = base + $urandom_range(jitter, 4 * jitter + 1000);
         end
      end
   endtask

   // Sender pause: everything accepted, every set entry back, then let the
   // back end finish any drop sweep that produces no output.
   task automatic wait_drained();
      while (words_accepted != words_queued || match_words_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerance(bit [msta_pkg::TS_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tolerance_model = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: one word in flight, a random gap between words while idling is on.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_word  <= req_backlog.pop_front();
            req_valid <= 1'b1;
            req_gap = idle_on ? $urandom_range(0, 4) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: a random stall after each word while idling is on; a requested long
   // hold backs the DUT up into its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_stall = LONG_HOLD;
         end else if (rsp_fire && idle_on) begin
            rsp_stall = $urandom_range(0, 4);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: check output words against the oldest due entry, feed accepted
   // input words to the predictor.
   always @(posedge clock) begin
      msta_pkg::rsp_word_type want;
      req_fire <= req_valid && req_ready && !reset;
      rsp_fire <= rsp_valid && rsp_ready && !reset;
      if (!reset && rsp_valid && rsp_ready) begin
         if (match_words_due.size() == 0) begin
            $error("result word with none due: 0x%0h", rsp_word);
            fail_count++;
         end else begin
            want = match_words_due.pop_front();
            check_field("out_stream",  32'(want.out_stream),  32'(rsp_word.out_stream));
            check_field("frame_index", 32'(want.frame_index), 32'(rsp_word.frame_index));
            check_field("last",        32'(want.last),        32'(rsp_word.last));
            check_field("overflow",    32'(want.overflow),    32'(rsp_word.overflow));
            results_checked++;
            if (want.last) sets_checked++;
         end
      end
      if (!reset && req_valid && req_ready) begin
         words_accepted++;
         align_push(req_word);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_multi_stream_timestamp_aligner: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int empty_sid;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset tolerance of 33333.
      // all-zero and all-ones timestamps: both match
      for (int s = 0; s < NS; s++) queue_word(s, 32'h0000_0000);
      for (int s = 0; s < NS; s++) queue_word(s, 32'hFFFF_FFFF);
      // spread exactly at tolerance: match
      queue_word(0, 32'd1000);
      queue_word(1, 32'd34333);
      queue_word(2, 32'd20000);
      queue_word(3, 32'd1000);
      // spread one over: streams 0 and 1 tie low, stream 0 is dropped
      queue_word(0, 32'd5000);
      queue_word(1, 32'd5000);
      queue_word(2, 32'd38334);
      queue_word(3, 32'd6000);
      // one over again: drop stream 1, then match; the stream 3 word waits
      queue_word(0, 32'd38000);
      queue_word(1, 32'd38334);
      queue_word(3, 32'd38100);
      wait_drained();

      // zero tolerance: only identical heads match
      write_tolerance(32'h0000_0000);
      queue_traffic(30, 1);
      wait_drained();

      // all-ones tolerance with no idling on either side: every full set matches
      write_tolerance(32'hFFFF_FFFF);
      idle_on = 1'b0;
      queue_traffic(40, 50000);
      wait_drained();

      // mid tolerance, output held off long enough to stall the input
      write_tolerance($urandom_range(5000, 60000));
      idle_on = 1'b1;
      @(posedge clock);
      hold_requests++;
      queue_traffic(70, 40000);
      wait_drained();

      write_tolerance(msta_pkg::TOL_RESET);
      queue_traffic(80, 40000);
      wait_drained();

      // Overflow: some stream is always empty once drained; push one more than
      // the queue holds onto the next stream so nothing can drain it.
      empty_sid = 0;
      for (int s = NS - 1; s >= 0; s--)
         if (ring_count[s] == 0) empty_sid = s;
      repeat (QD + 1) queue_word((empty_sid + 1) % NS, $urandom);
      wait_drained();

      // sets after overflow carry the sticky flag
      write_tolerance($urandom_range(100000, 1000000));
      queue_traffic(60, 300000);
      wait_drained();

      $display("covered %0d input words, %0d matched sets (%0d result words) checked",
               words_accepted, sets_checked, results_checked);
      $display("tolerance 0, reset, mid and all-ones; long output stall; queue overflow");
      if (fail_count == 0 && match_words_due.size() == 0) begin
         $display("tb_multi_stream_timestamp_aligner: PASS");
      end else begin
         $display("tb_multi_stream_timestamp_aligner: FAIL");
      end
      $finish;
   end

endmodule
